>>> hdl/pcf_pkg.sv
// shared constants, control struct and arctangent table for the pitch filter
`default_nettype none

package pcf_pkg;

  localparam int unsigned XY_W    = 28;
  localparam int unsigned Z_W     = 35;
  localparam int unsigned ATAN_W  = 30;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned STEP_W  = $clog2(SCALE_W);

  localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] PI_Q30 = (PI_Q62 + 64'h0000_0000_8000_0000) >> 32;

  typedef struct packed {
    logic              load;
    logic              step;
    logic [STEP_W-1:0] idx;
  } cordic_ctrl_t;

  function automatic logic [ATAN_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'd843314857;
      5'd1:    v = 30'd497837830;
      5'd2:    v = 30'd263043837;
      5'd3:    v = 30'd133525159;
      5'd4:    v = 30'd67021687;
      5'd5:    v = 30'd33543515;
      5'd6:    v = 30'd16775850;
      5'd7:    v = 30'd8388438;
      5'd8:    v = 30'd4194283;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048576;
      5'd11:   v = 30'd524288;
      5'd12:   v = 30'd262144;
      5'd13:   v = 30'd131072;
      5'd14:   v = 30'd65536;
      5'd15:   v = 30'd32768;
      5'd16:   v = 30'd16384;
      5'd17:   v = 30'd8192;
      5'd18:   v = 30'd4096;
      5'd19:   v = 30'd2048;
      5'd20:   v = 30'd1024;
      5'd21:   v = 30'd512;
      5'd22:   v = 30'd256;
      5'd23:   v = 30'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/pcf_cordic.sv
// iterative vectoring cordic giving the accelerometer pitch angle
`default_nettype none

module pcf_cordic #(
  parameter int unsigned ANGLE_FRACTION_BITS = 13,
  localparam int unsigned ACC_W = pcf_pkg::Z_W - 30 + ANGLE_FRACTION_BITS
) (
  input  wire logic                        clk_i,
  input  wire pcf_pkg::cordic_ctrl_t       ctrl_i,
  input  wire logic signed [15:0]          accel_x_i,
  input  wire logic signed [15:0]          accel_z_i,
  output logic signed [ACC_W-1:0]          angle_o
);

  localparam int unsigned XY_W = pcf_pkg::XY_W;
  localparam int unsigned Z_W  = pcf_pkg::Z_W;
  localparam logic signed [Z_W-1:0] PI_Z = Z_W'(pcf_pkg::PI_Q30);
  localparam logic signed [Z_W-1:0] RND_Z = Z_W'(64'd1 << (29 - ANGLE_FRACTION_BITS));

  logic signed [XY_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]  z_q, z_d;
  logic                   zero_q, zero_d;
  logic signed [XY_W-1:0] ax_w, az_w, xs, ys;
  logic signed [Z_W-1:0]  at, rnd;

  assign ax_w = {{(XY_W-24){accel_x_i[15]}}, accel_x_i, 8'h00};
  assign az_w = {{(XY_W-24){accel_z_i[15]}}, accel_z_i, 8'h00};
  assign xs   = x_q >>> ctrl_i.idx;
  assign ys   = y_q >>> ctrl_i.idx;
  assign at   = signed'({{(Z_W-pcf_pkg::ATAN_W){1'b0}}, pcf_pkg::atan_q30(ctrl_i.idx)});

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    zero_d = zero_q;
    if (ctrl_i.load) begin
      zero_d = (accel_x_i == 16'sd0) && (accel_z_i == 16'sd0);
      if (accel_z_i[15]) begin
        // left half plane: rotate by pi first
        x_d = -az_w;
        y_d = -ax_w;
        z_d = accel_x_i[15] ? -PI_Z : PI_Z;
      end else begin
        x_d = az_w;
        y_d = ax_w;
        z_d = '0;
      end
    end else if (ctrl_i.step) begin
      if (!y_q[XY_W-1]) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

  assign rnd     = z_q + RND_Z;
  assign angle_o = zero_q ? '0 : ACC_W'(rnd >>> (30 - ANGLE_FRACTION_BITS));

endmodule

`default_nettype wire

>>> hdl/pitch_complementary_filter.sv
// top level of the accelerometer and gyro pitch complementary filter
//
// One pitch beat (Q2.13 radians at the default fraction width, saturated to
// +-pi) comes out for every input beat. An item is taken in state IDLE,
// then state MULA forms gyro magnitude times elapsed time, state RUN runs
// the bit-serial multiply by the gyro scale register (the cordic iterations
// run alongside in the same window), and states SUM, MUL and FIN saturate
// the gyro path, blend and round. FIN holds until the output register is
// free. A new item is taken only in IDLE, after the last one has left FIN.
// A finished pitch waits in the output register while the next item is
// already being worked on. Registers: alpha weight at byte address 0, gyro
// time scale at byte address 4; write them only while the block is idle.
`default_nettype none

module pitch_complementary_filter #(
  parameter int unsigned CORDIC_STEPS        = 16,
  parameter int unsigned ANGLE_FRACTION_BITS = 13
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_z_i,
  input  wire logic signed [15:0] gyro_y_i,
  input  wire logic [31:0]        timestamp_us_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      pitch_o
);

  localparam int unsigned STEP_W  = pcf_pkg::STEP_W;
  localparam int unsigned SCALE_W = pcf_pkg::SCALE_W;
  localparam int unsigned ACC_W   = pcf_pkg::Z_W - 30 + ANGLE_FRACTION_BITS;
  localparam int unsigned DIFF_W  = ((ACC_W > 32) ? ACC_W : 32) + 1;
  localparam int unsigned PROD_W  = DIFF_W + 17;
  localparam int unsigned BL_W    = PROD_W + 1;
  localparam int unsigned RES_W   = BL_W - 16;
  localparam int unsigned P1_W    = 48;
  localparam int unsigned GSUM_W  = P1_W + 2;
  localparam logic [63:0] PI_QF =
    (pcf_pkg::PI_Q62 + (64'd1 << (61 - ANGLE_FRACTION_BITS))) >> (62 - ANGLE_FRACTION_BITS);
  localparam logic signed [RES_W-1:0]  PI_R   = RES_W'(PI_QF);
  localparam logic signed [GSUM_W-1:0] GP_LIM = GSUM_W'(64'h7FFF_FFFF);
  localparam logic [15:0]  ALPHA_RST = 16'd64880;
  localparam logic [31:0]  SCALE_RST = 32'd4686;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MULA = 6'b000010,
    S_RUN  = 6'b000100,
    S_SUM  = 6'b001000,
    S_MUL  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [15:0]              alpha_q;
  logic [31:0]              scale_q;
  logic [31:0]              last_time_q;
  logic signed [15:0]       prev_q, prev_d;
  logic [STEP_W-1:0]        cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;

  logic [31:0]              dt_q;
  logic [15:0]              gmag_q;
  logic                     gneg_q;
  logic [SCALE_W-1:0]       s_q;
  logic [P1_W-1:0]          p1_q, h_q;
  logic signed [31:0]       gp_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [15:0]       pitch_q;

  logic                     accept, cfg_wr, out_free;
  logic [P1_W:0]            ser_sum;
  logic signed [GSUM_W-1:0] hs, gsum;
  logic signed [31:0]       gp_d;
  logic signed [DIFF_W-1:0] diff;
  logic signed [16:0]       alpha_s;
  logic signed [BL_W-1:0]   bl;
  logic signed [RES_W-1:0]  res, res_sat;
  logic signed [ACC_W-1:0]  angle;
  pcf_pkg::cordic_ctrl_t    cctrl;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? scale_q : {16'h0000, alpha_q};

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign pitch_o     = pitch_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign cctrl.load = accept;
  assign cctrl.step = (state_q == S_RUN) &&
                      ({1'b0, cnt_q} < (STEP_W+1)'(CORDIC_STEPS));
  assign cctrl.idx  = cnt_q;

  pcf_cordic #(
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_cordic (
    .clk_i     (clk_i),
    .ctrl_i    (cctrl),
    .accel_x_i (accel_x_i),
    .accel_z_i (accel_z_i),
    .angle_o   (angle)
  );

  // serial scale multiply, one scale bit per cycle, low bits drop out
  assign ser_sum = {1'b0, h_q} + (s_q[0] ? {1'b0, p1_q} : '0);

  // gyro path with saturation
  assign hs   = signed'({2'b00, h_q});
  assign gsum = GSUM_W'(prev_q) + (gneg_q ? -hs : hs);
  always_comb begin
    if (gsum > GP_LIM) begin
      gp_d = 32'(GP_LIM);
    end else if (gsum < -GP_LIM) begin
      gp_d = 32'(-GP_LIM);
    end else begin
      gp_d = gsum[31:0];
    end
  end

  // blend as acc + (gyro - acc) * alpha
  assign diff    = DIFF_W'(gp_q) - DIFF_W'(acc_q);
  assign alpha_s = signed'({1'b0, alpha_q});
  assign bl      = (BL_W'(acc_q) <<< 16) + BL_W'(prod_q) + BL_W'(32'sd32768);
  assign res     = bl[BL_W-1:16];
  always_comb begin
    if (res > PI_R) begin
      res_sat = PI_R;
    end else if (res < -PI_R) begin
      res_sat = -PI_R;
    end else begin
      res_sat = res;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_MULA;
        end
      end
      S_MULA: begin
        cnt_d   = '0;
        state_d = S_RUN;
      end
      S_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(SCALE_W - 1)) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          prev_d      = res_sat[15:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      last_time_q <= '0;
      alpha_q     <= ALPHA_RST;
      scale_q     <= SCALE_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      prev_q      <= prev_d;
      if (accept) begin
        last_time_q <= timestamp_us_i;
      end
      if (cfg_wr) begin
        if (paddr[2]) begin
          scale_q <= pwdata;
        end else begin
          alpha_q <= pwdata[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q   <= timestamp_us_i - last_time_q;
      gmag_q <= gyro_y_i[15] ? 16'(-gyro_y_i) : gyro_y_i;
      gneg_q <= gyro_y_i[15];
      s_q    <= scale_q;
    end
    if (state_q == S_MULA) begin
      p1_q <= gmag_q * dt_q;
      h_q  <= '0;
    end
    if (state_q == S_RUN) begin
      h_q <= ser_sum[P1_W:1];
      s_q <= s_q >> 1;
    end
    if (state_q == S_SUM) begin
      gp_q  <= gp_d;
      acc_q <= angle;
    end
    if (state_q == S_MUL) begin
      prod_q <= diff * alpha_s;
    end
    if ((state_q == S_FIN) && out_free) begin
      pitch_q <= res_sat[15:0];
    end
  end

endmodule

`default_nettype wire
